@@ sv/clcq_pkg.sv @@
package clcq_pkg;

    localparam int ELEMENTS = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_QUEUED    = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd3;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] elem_index;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] element_count;
        logic [IDX_W-1:0] head_index;
        logic             queue_empty;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       commit;
        logic       op;
        logic       ok;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic member;
        logic empty;
    } t_dp_stat;

endpackage

@@ sv/circular_linked_queue_unit.sv @@
// Channel  | Valid / flow        | Payload
// ---------+---------------------+---------------------------
// item in  | start, busy         | i_item   (op, elem_index)
// result   | o_done (one cycle)  | o_result (status, element_count, head_index, queue_empty)
//
// Each item is handled in order: at accept the link tables are read and, for an
// append, the first pair of links is written; while busy, the second pair of links is
// written back and count, head and membership are updated. o_done pulses in the cycle
// after busy, while the next item may already be accepted; no item is taken while busy.
// Synchronous reset clears the queue; link tables need no reset.
// The receiver cannot stall; each result is valid for exactly one cycle.
module circular_linked_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  clcq_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_done,
    output clcq_pkg::t_result o_result
);
    import clcq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    clcq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    clcq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

@@ sv/clcq_ctrl.sv @@
module clcq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  clcq_pkg::t_item   i_item,
    input  clcq_pkg::t_dp_stat i_stat,
    output logic              busy,
    output clcq_pkg::t_dp_cmd o_cmd
);
    import clcq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic       r_state, n_state;
    logic       r_op, n_op;
    logic [1:0] r_status, n_status;
    logic [1:0] status_now;
    logic       accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        if (i_item.op == OP_APPEND) begin
            status_now = i_stat.member ? ST_QUEUED : ST_OK;
        end else if (i_stat.empty) begin
            status_now = ST_EMPTY;
        end else begin
            status_now = i_stat.member ? ST_OK : ST_NOT_QUEUED;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_FIN;
                    n_op     = i_item.op;
                    n_status = status_now;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.accept = accept;
        o_cmd.commit = (r_state == S_FIN);
        o_cmd.op     = accept ? i_item.op : r_op;
        o_cmd.status = accept ? status_now : r_status;
        o_cmd.ok     = (o_cmd.status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op     <= n_op;
        r_status <= n_status;
    end

endmodule

@@ sv/clcq_dp.sv @@
module clcq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clcq_pkg::t_item    i_item,
    input  clcq_pkg::t_dp_cmd  i_cmd,
    output clcq_pkg::t_dp_stat o_stat,
    output logic               o_done,
    output clcq_pkg::t_result  o_result
);
    import clcq_pkg::*;

    logic [IDX_W-1:0] mem_next [ELEMENTS];
    logic [IDX_W-1:0] mem_prev [ELEMENTS];

    logic [ELEMENTS-1:0] r_member, n_member;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_elem;
    logic [IDX_W-1:0]    r_next_rd, r_prev_rd;
    logic                r_done;
    t_result             r_result;

    logic [IDX_W-1:0] prev_raddr;
    logic             next_we, prev_we;
    logic [IDX_W-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic             empty, single;

    assign empty  = (r_count == '0);
    assign single = (r_count == CNT_W'(1));

    assign o_stat.member = r_member[i_item.elem_index];
    assign o_stat.empty  = empty;

    // append needs the tail (prev of head); remove needs both links of the element
    assign prev_raddr = (i_item.op == OP_REMOVE) ? i_item.elem_index : r_head;

    // link writes: first half at accept, second half once the read data is back
    always_comb begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        next_waddr = i_item.elem_index;
        next_wdata = r_head;
        prev_waddr = r_head;
        prev_wdata = i_item.elem_index;
        if (i_cmd.accept && i_cmd.ok && (i_cmd.op == OP_APPEND)) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            if (empty) begin
                next_wdata = i_item.elem_index;
                prev_waddr = i_item.elem_index;
            end
        end else if (i_cmd.commit && i_cmd.ok) begin
            if (i_cmd.op == OP_APPEND) begin
                next_we    = !empty;
                prev_we    = !empty;
                next_waddr = r_prev_rd;
                next_wdata = r_elem;
                prev_waddr = r_elem;
                prev_wdata = r_prev_rd;
            end else begin
                next_we    = !single;
                prev_we    = !single;
                next_waddr = r_prev_rd;
                next_wdata = r_next_rd;
                prev_waddr = r_next_rd;
                prev_wdata = r_prev_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_rd <= mem_next[i_item.elem_index];
        r_prev_rd <= mem_prev[prev_raddr];
        if (next_we) begin
            mem_next[next_waddr] <= next_wdata;
        end
        if (prev_we) begin
            mem_prev[prev_waddr] <= prev_wdata;
        end
    end

    always_comb begin
        n_member = r_member;
        n_head   = r_head;
        n_count  = r_count;
        if (i_cmd.commit && i_cmd.ok) begin
            if (i_cmd.op == OP_APPEND) begin
                n_member[r_elem] = 1'b1;
                n_count          = r_count + CNT_W'(1);
                if (empty) begin
                    n_head = r_elem;
                end
            end else begin
                n_member[r_elem] = 1'b0;
                n_count          = r_count - CNT_W'(1);
                if (single) begin
                    n_head = '0;
                end else if (r_elem == r_head) begin
                    n_head = r_next_rd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_member <= n_member;
            r_head   <= n_head;
            r_count  <= n_count;
            r_done   <= i_cmd.commit;
        end
        if (i_cmd.accept) begin
            r_elem <= i_item.elem_index;
        end
        if (i_cmd.commit) begin
            r_result.status        <= i_cmd.status;
            r_result.element_count <= n_count;
            r_result.head_index    <= (n_count == '0) ? '0 : n_head;
            r_result.queue_empty   <= (n_count == '0);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ sv/clcq_chk.sv @@
module clcq_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input clcq_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_done,
    input clcq_pkg::t_result o_result
);
    import clcq_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_two_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result missing two cycles after accept");

    a_done_only_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result without a finished item");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.queue_empty == (o_result.element_count == '0)) &&
                    (!o_result.queue_empty || (o_result.head_index == '0))))
        else $error("empty flag, count and head disagree");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.element_count <= CNT_W'(ELEMENTS)))
        else $error("count beyond pool size");

endmodule

bind circular_linked_queue_unit clcq_chk u_clcq_chk (.*);
